// ===== sv/gcrc_pkg.sv =====
`default_nettype none
package gcrc_pkg;

  // datapath widths of the two CORDIC chains
  localparam int CW = 34;
  localparam int VW = 36;
  localparam int MAX_STAGES = 32;

  // pi/180 in Q.40, split for two partial products
  localparam logic [34:0] DEG2RAD_Q40 = 35'd19190098069;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [13:0] TWO_R_KM = 14'd12742;

  // floor(2^38 / 1000) for the range scaling
  localparam logic [28:0] RECIP_1000 = 29'd274877906;
  localparam logic [28:0] ROUND_500 = 29'd500;
  localparam logic [10:0] DIV_1000 = 11'd1000;

  // last entry is atan(2^-31) in Q.30, which rounds up to one
  localparam logic [29:0] ATAN_Q30 [MAX_STAGES] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
    30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
    30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
    30'd262144,    30'd131072,    30'd65536,     30'd32768,
    30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128,
    30'd64,        30'd32,        30'd16,        30'd8,
    30'd4,         30'd2,         30'd1,         30'd1
  };

  // inverse CORDIC gain in Q.30 for n stages, evaluated at elaboration
  function automatic logic [31:0] gain_inv(input int n);
    logic [63:0] a2;
    logic [63:0] rem_v;
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] num;
    logic [64:0] r;
    logic [31:0] q;
    a2 = 64'd1 << 60;
    for (int i = 0; i < MAX_STAGES; i++) begin
      if (i < n) a2 = a2 + (a2 >> (2 * i));
    end
    res = '0;
    bit_v = 64'd1 << 62;
    rem_v = a2;
    for (int k = 0; k < 32; k++) begin
      if (rem_v >= res + bit_v) begin
        rem_v = rem_v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    num = (64'd1 << 60) + (res >> 1);
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, res}) begin
        r = r - {1'b0, res};
        if (b < 32) q[b] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage
`default_nettype wire

// ===== sv/gcrc_sqrt_cell.sv =====
`default_nettype none
// one digit of a restoring integer square root
module gcrc_sqrt_cell #(
  parameter int W = 64,
  parameter int STAGE = 0
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] n_i,
  input  logic [W-1:0] q_i,
  output logic [W-1:0] n_o,
  output logic [W-1:0] q_o
);

  localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * STAGE);

  logic [W-1:0] trial;
  logic [W-1:0] n_nxt;
  logic [W-1:0] q_nxt;
  logic [W-1:0] n_r;
  logic [W-1:0] q_r;

  always_comb begin
    trial = q_i + BIT;
    if (n_i >= trial) begin
      n_nxt = n_i - trial;
      q_nxt = (q_i >> 1) + BIT;
    end else begin
      n_nxt = n_i;
      q_nxt = q_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_nxt;
      q_r <= q_nxt;
    end
  end

  assign n_o = n_r;
  assign q_o = q_r;

endmodule
`default_nettype wire

// ===== sv/gcrc_rot_cell.sv =====
`default_nettype none
// rotation-mode CORDIC micro-rotation
module gcrc_rot_cell #(
  parameter int STAGE = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [gcrc_pkg::CW-1:0] x_i,
  input  logic signed [gcrc_pkg::CW-1:0] y_i,
  input  logic signed [gcrc_pkg::CW-1:0] z_i,
  output logic signed [gcrc_pkg::CW-1:0] x_o,
  output logic signed [gcrc_pkg::CW-1:0] y_o,
  output logic signed [gcrc_pkg::CW-1:0] z_o
);

  localparam logic signed [gcrc_pkg::CW-1:0] ANG =
    {{(gcrc_pkg::CW-30){1'b0}}, gcrc_pkg::ATAN_Q30[STAGE]};

  logic signed [gcrc_pkg::CW-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [gcrc_pkg::CW-1:0] x_r, y_r, z_r;

  always_comb begin
    if (!z_i[gcrc_pkg::CW-1]) begin
      x_nxt = x_i - (y_i >>> STAGE);
      y_nxt = y_i + (x_i >>> STAGE);
      z_nxt = z_i - ANG;
    end else begin
      x_nxt = x_i + (y_i >>> STAGE);
      y_nxt = y_i - (x_i >>> STAGE);
      z_nxt = z_i + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule
`default_nettype wire

// ===== sv/gcrc_vec_cell.sv =====
`default_nettype none
// vectoring-mode CORDIC micro-rotation, drives y toward zero
module gcrc_vec_cell #(
  parameter int STAGE = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [gcrc_pkg::VW-1:0] x_i,
  input  logic signed [gcrc_pkg::VW-1:0] y_i,
  input  logic signed [gcrc_pkg::VW-1:0] z_i,
  output logic signed [gcrc_pkg::VW-1:0] x_o,
  output logic signed [gcrc_pkg::VW-1:0] y_o,
  output logic signed [gcrc_pkg::VW-1:0] z_o
);

  localparam logic signed [gcrc_pkg::VW-1:0] ANG =
    {{(gcrc_pkg::VW-30){1'b0}}, gcrc_pkg::ATAN_Q30[STAGE]};

  logic signed [gcrc_pkg::VW-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [gcrc_pkg::VW-1:0] x_r, y_r, z_r;

  always_comb begin
    if (!y_i[gcrc_pkg::VW-1]) begin
      x_nxt = x_i + (y_i >>> STAGE);
      y_nxt = y_i - (x_i >>> STAGE);
      z_nxt = z_i + ANG;
    end else begin
      x_nxt = x_i - (y_i >>> STAGE);
      y_nxt = y_i + (x_i >>> STAGE);
      z_nxt = z_i - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule
`default_nettype wire

// ===== sv/great_circle_range_check.sv =====
`default_nettype none
// The datapath runs through two N-cell CORDIC chains and two 32-cell square-root chains,
// where N = min(CORDIC_STAGES, 32).
// Throughput: one item per cycle; an output register plus one skid entry keep
// the input open while a result waits. The pipeline stalls only when both are full.
// Reset (rst_n low, synchronous) clears all valid bits; no clearing pass is needed.
module great_circle_range_check #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_lat_a,
  input  logic signed [24:0] in_lon_a,
  input  logic signed [23:0] in_lat_b,
  input  logic signed [24:0] in_lon_b,
  input  logic        [23:0] in_power_a,
  input  logic        [23:0] in_power_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [30:0] out_distance,
  output logic               out_in_reach,
  output logic               out_conflict
);

  localparam int CW = gcrc_pkg::CW;
  localparam int VW = gcrc_pkg::VW;
  localparam int NSTG = (CORDIC_STAGES > gcrc_pkg::MAX_STAGES) ?
                        gcrc_pkg::MAX_STAGES : CORDIC_STAGES;
  localparam int LAT = 74 + 2 * NSTG;
  localparam int RA_DLY = 43 + 2 * NSTG;
  localparam logic [31:0] GAIN_INV = gcrc_pkg::gain_inv(NSTG);

  localparam logic signed [25:0] DEG_FULL = 26'sd23592960;
  localparam logic signed [25:0] DEG_HALF = 26'sd11796480;
  localparam logic signed [25:0] DEG_QTR  = 26'sd5898240;

  typedef struct packed {
    logic [22:0] mag;
    logic        sgn;
    logic        neg;
  } fold_t;

  // wrap to (-180, 180], then fold into [-90, 90] noting the sign flip
  function automatic fold_t fold(input logic signed [25:0] a);
    logic signed [25:0] d;
    fold_t f;
    d = a;
    f.neg = 1'b0;
    if (d > DEG_HALF) d = d - DEG_FULL;
    else if (d <= -DEG_HALF) d = d + DEG_FULL;
    if (d > DEG_QTR) begin
      d = d - DEG_HALF;
      f.neg = 1'b1;
    end else if (d < -DEG_QTR) begin
      d = d + DEG_HALF;
      f.neg = 1'b1;
    end
    f.sgn = d[25];
    f.mag = d[25] ? 23'(-d) : 23'(d);
    return f;
  endfunction

  // degrees to radians, rounded half up at bit 26
  function automatic logic [31:0] zmag(input logic [40:0] hi, input logic [39:0] lo);
    logic [57:0] s;
    s = {hi, 17'b0} + 58'(lo) + (58'd1 << 25);
    return s[57:26];
  endfunction

  logic adv;
  logic [LAT-1:0] v_r;
  logic out_valid_r, skid_valid_r;
  logic out_free;

  assign adv = !skid_valid_r;
  assign in_ready = adv;
  assign out_free = !out_valid_r || out_ready;

  // ---------------- angle front end ----------------
  logic signed [25:0] dlon;
  fold_t fa, fb, fd;
  fold_t f_r [3];
  logic [2:0] neg_d [NSTG+3];
  logic [40:0] pph_r [3];
  logic [39:0] ppl_r [3];
  logic sgn1_r [3];
  logic signed [CW-1:0] z0_r [3];

  assign dlon = 26'(in_lon_a) - 26'(in_lon_b);

  always_comb begin
    fa = fold(26'(in_lat_a));
    fb = fold(26'(in_lat_b));
    fd = fold(dlon);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r[0] <= fa;
      f_r[1] <= fb;
      f_r[2] <= fd;
      neg_d[0] <= {fd.neg, fb.neg, fa.neg};
      for (int k = 1; k < NSTG + 3; k++) neg_d[k] <= neg_d[k-1];
      for (int l = 0; l < 3; l++) begin
        pph_r[l] <= f_r[l].mag * gcrc_pkg::DEG2RAD_Q40[34:17];
        ppl_r[l] <= f_r[l].mag * gcrc_pkg::DEG2RAD_Q40[16:0];
        sgn1_r[l] <= f_r[l].sgn;
      end
      for (int l = 0; l < 3; l++) begin
        z0_r[l] <= sgn1_r[l] ? -{{(CW-32){1'b0}}, zmag(pph_r[l], ppl_r[l])}
                             :  {{(CW-32){1'b0}}, zmag(pph_r[l], ppl_r[l])};
      end
    end
  end

  // ---------------- rotation CORDIC, three lanes ----------------
  logic signed [CW-1:0] rx [3][NSTG+1];
  logic signed [CW-1:0] ry [3][NSTG+1];
  logic signed [CW-1:0] rz [3][NSTG+1];

  genvar gl, gs;
  generate
    for (gl = 0; gl < 3; gl++) begin : g_lane
      assign rx[gl][0] = {{(CW-32){1'b0}}, GAIN_INV};
      assign ry[gl][0] = '0;
      assign rz[gl][0] = z0_r[gl];
      for (gs = 0; gs < NSTG; gs++) begin : g_rot
        gcrc_rot_cell #(.STAGE(gs)) u_cell (
          .clk (clk),
          .en  (adv),
          .x_i (rx[gl][gs]),
          .y_i (ry[gl][gs]),
          .z_i (rz[gl][gs]),
          .x_o (rx[gl][gs+1]),
          .y_o (ry[gl][gs+1]),
          .z_o (rz[gl][gs+1])
        );
      end
    end
  endgenerate

  // ---------------- chord ----------------
  logic signed [31:0] cv [3];
  logic signed [31:0] sv [3];
  logic signed [63:0] px_r, py_r;
  logic signed [32:0] dz_r;
  logic signed [31:0] c2_r;
  logic signed [33:0] rxq, ryq;
  logic signed [34:0] dx;
  logic [31:0] adx_r, ady_r, adz_r;
  logic [63:0] sqx_r, sqy_r, sqz_r, sum_r;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      cv[l] = neg_d[NSTG+2][l] ? 32'(-rx[l][NSTG]) : 32'(rx[l][NSTG]);
      sv[l] = neg_d[NSTG+2][l] ? 32'(-ry[l][NSTG]) : 32'(ry[l][NSTG]);
    end
    rxq = 34'((px_r + 64'sd536870912) >>> 30);
    ryq = 34'((py_r + 64'sd536870912) >>> 30);
    dx = 35'(rxq) - 35'(c2_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= cv[2] * cv[0];
      py_r <= sv[2] * cv[0];
      dz_r <= 33'(sv[0]) - 33'(sv[1]);
      c2_r <= cv[1];
      adx_r <= dx[34] ? 32'(-dx) : 32'(dx);
      ady_r <= ryq[33] ? 32'(-ryq) : 32'(ryq);
      adz_r <= dz_r[32] ? 32'(-dz_r) : 32'(dz_r);
      sqx_r <= adx_r * adx_r;
      sqy_r <= ady_r * ady_r;
      sqz_r <= adz_r * adz_r;
      sum_r <= sqx_r + sqy_r + sqz_r;
    end
  end

  // ---------------- half chord: sqrt, clamp, sqrt(1 - h^2) ----------------
  logic [63:0] s1n [33];
  logic [63:0] s1q [33];
  logic [63:0] s2n [33];
  logic [63:0] s2q [33];
  logic [31:0] h_d [33];
  logic [63:0] hh_r;
  logic [31:0] h_cl;

  assign s1n[0] = sum_r;
  assign s1q[0] = '0;
  assign s2n[0] = (64'd1 << 62) - hh_r;
  assign s2q[0] = '0;
  assign h_cl = (s1q[32] > (64'd1 << 31)) ? 32'h8000_0000 : s1q[32][31:0];

  generate
    for (gs = 0; gs < 32; gs++) begin : g_sq
      gcrc_sqrt_cell #(.W(64), .STAGE(gs)) u_s1 (
        .clk (clk), .en (adv),
        .n_i (s1n[gs]), .q_i (s1q[gs]),
        .n_o (s1n[gs+1]), .q_o (s1q[gs+1])
      );
      gcrc_sqrt_cell #(.W(64), .STAGE(gs)) u_s2 (
        .clk (clk), .en (adv),
        .n_i (s2n[gs]), .q_i (s2q[gs]),
        .n_o (s2n[gs+1]), .q_o (s2q[gs+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv) begin
      h_d[0] <= h_cl;
      hh_r <= h_cl * h_cl;
      for (int k = 1; k < 33; k++) h_d[k] <= h_d[k-1];
    end
  end

  // ---------------- asin by vectoring CORDIC ----------------
  logic signed [VW-1:0] vx [NSTG+1];
  logic signed [VW-1:0] vy [NSTG+1];
  logic signed [VW-1:0] vz [NSTG+1];

  assign vx[0] = {{(VW-32){1'b0}}, s2q[32][31:0]};
  assign vy[0] = {{(VW-32){1'b0}}, h_d[32]};
  assign vz[0] = '0;

  generate
    for (gs = 0; gs < NSTG; gs++) begin : g_vec
      gcrc_vec_cell #(.STAGE(gs)) u_cell (
        .clk (clk),
        .en  (adv),
        .x_i (vx[gs]),
        .y_i (vy[gs]),
        .z_i (vz[gs]),
        .x_o (vx[gs+1]),
        .y_o (vy[gs+1]),
        .z_o (vz[gs+1])
      );
    end
  endgenerate

  // ---------------- ranges: sqrt(power) / 1000 ----------------
  logic [55:0] pn [2][29];
  logic [55:0] pq [2][29];
  logic [28:0] rxv_r [2];
  logic [57:0] rp_r [2];
  logic [19:0] qe_w [2];
  logic [18:0] qe_r [2];
  logic [10:0] rem_r [2];
  logic [18:0] rng_d [2][RA_DLY];

  assign pn[0][0] = {in_power_a, 32'b0};
  assign pn[1][0] = {in_power_b, 32'b0};
  assign pq[0][0] = '0;
  assign pq[1][0] = '0;

  generate
    for (gl = 0; gl < 2; gl++) begin : g_pw
      for (gs = 0; gs < 28; gs++) begin : g_psq
        gcrc_sqrt_cell #(.W(56), .STAGE(gs)) u_cell (
          .clk (clk), .en (adv),
          .n_i (pn[gl][gs]), .q_i (pq[gl][gs]),
          .n_o (pn[gl][gs+1]), .q_o (pq[gl][gs+1])
        );
      end
      assign qe_w[gl] = rp_r[gl][57:38];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        rxv_r[l] <= pq[l][28][28:0] + gcrc_pkg::ROUND_500;
        rp_r[l] <= (pq[l][28][28:0] + gcrc_pkg::ROUND_500) * gcrc_pkg::RECIP_1000;
        qe_r[l] <= 19'(qe_w[l]);
        rem_r[l] <= 11'(30'(rxv_r[l]) - 30'(qe_w[l]) * 30'(gcrc_pkg::DIV_1000));
        // reciprocal estimate is at most one short
        rng_d[l][0] <= (rem_r[l] >= gcrc_pkg::DIV_1000) ? qe_r[l] + 19'd1 : qe_r[l];
        for (int k = 1; k < RA_DLY; k++) rng_d[l][k] <= rng_d[l][k-1];
      end
    end
  end

  // ---------------- distance and flags ----------------
  logic signed [VW-1:0] ang;
  logic [30:0] ang_cl;
  logic [44:0] dprod_r;
  logic [44:0] dsum;
  logic [30:0] dist_w;
  logic [30:0] td_r;
  logic treach_r, tconf_r;
  logic [30:0] skd_r;
  logic sreach_r, sconf_r;
  logic [30:0] od_r;
  logic oreach_r, oconf_r;

  always_comb begin
    ang = vz[NSTG];
    if (ang[VW-1]) ang_cl = '0;
    else if (ang > signed'({{(VW-31){1'b0}}, gcrc_pkg::HALF_PI_Q30}))
      ang_cl = gcrc_pkg::HALF_PI_Q30;
    else ang_cl = ang[30:0];
    // product stays below 2^45, so adding the rounding term cannot overflow dsum
    dsum = dprod_r + (45'd1 << 13);
    dist_w = dsum[44:14];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dprod_r <= ang_cl * gcrc_pkg::TWO_R_KM;
      td_r <= dist_w;
      treach_r <= dist_w <= 31'(rng_d[0][RA_DLY-1]);
      tconf_r <= 31'(rng_d[0][RA_DLY-1]) + 31'(rng_d[1][RA_DLY-1]) >= dist_w;
    end
  end

  // ---------------- output register and skid entry ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (adv) v_r <= {v_r[LAT-2:0], in_valid};
      if (skid_valid_r) begin
        if (out_free) begin
          out_valid_r <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (out_free) begin
        out_valid_r <= v_r[LAT-1];
      end else if (v_r[LAT-1]) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_free) begin
        od_r <= skd_r;
        oreach_r <= sreach_r;
        oconf_r <= sconf_r;
      end
    end else if (out_free) begin
      od_r <= td_r;
      oreach_r <= treach_r;
      oconf_r <= tconf_r;
    end else begin
      skd_r <= td_r;
      sreach_r <= treach_r;
      sconf_r <= tconf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_distance = od_r;
  assign out_in_reach = oreach_r;
  assign out_conflict = oconf_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds data while output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_ready |=> !skid_valid_r)
    else $error("skid entry not drained after output transfer");

  a_reach_implies_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_reach |-> out_conflict)
    else $error("in_reach set without conflict");

endmodule
`default_nettype wire
